[design/sentence_index_mark_inserter_top_defines.svh]
// assertion macros shared by the mark inserter modules
`ifndef SENTENCE_INDEX_MARK_INSERTER_TOP_DEFINES_SVH
`define SENTENCE_INDEX_MARK_INSERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SIMI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SIMI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/simi_pkg.sv]
// types, constants and helpers for the sentence index mark inserter
package simi_pkg;

    localparam int CP_W            = 21;
    localparam int MARK_DIGITS_DEF = 5;
    localparam int FIFO_DEPTH_DEF  = 2;

    localparam logic [CP_W-1:0] CH_AT   = 21'h00040;
    localparam logic [CP_W-1:0] CH_DOT  = 21'h0002E;
    localparam logic [CP_W-1:0] CH_ZERO = 21'h00030;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            message_last;
    } in_word_t;

    typedef struct packed {
        logic [CP_W-1:0] out_code_point;
        logic            run_last;
        logic            message_end;
    } out_word_t;

    typedef enum logic [1:0] {
        BODY_NONE = 2'd0,
        BODY_CHAR = 2'd1,
        BODY_AT2  = 2'd2,
        BODY_MARK = 2'd3
    } body_e;

    typedef struct packed {
        logic            emit_dot;
        body_e           body;
        logic [CP_W-1:0] code_point;
        logic            last;
    } cmd_t;

    function automatic logic is_white(input logic [CP_W-1:0] c);
        logic w;
        w = (c == 21'h00009) || (c == 21'h0000A) || (c == 21'h0000C) ||
            (c == 21'h0000D) || (c == 21'h00020) || (c == 21'h000A0) ||
            (c == 21'h01680) || ((c >= 21'h02000) && (c <= 21'h0200A)) ||
            (c == 21'h02028) || (c == 21'h02029) || (c == 21'h0202F) ||
            (c == 21'h0205F) || (c == 21'h03000);
        return w;
    endfunction

endpackage

[design/simi_front.sv]
// front end: accepts words, tracks held-back period and mark number, issues commands
`include "sentence_index_mark_inserter_top_defines.svh"

module simi_front #(
    parameter int MARK_DIGITS = simi_pkg::MARK_DIGITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  simi_pkg::in_word_t        s_word,
    input  logic                      q_full,
    output logic                      q_push,
    output simi_pkg::cmd_t            q_cmd,
    output logic [4*MARK_DIGITS-1:0]  q_bcd
);
    import simi_pkg::*;

    localparam int BCD_W = 4 * MARK_DIGITS;

    logic             pend_reg, pend_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] bcd_inc;
    logic             accept, white, is_at, is_dot, mark, push;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_bcd   = bcd_reg;

    // saturating bcd increment
    always_comb begin
        logic       all_nine;
        logic       carry;
        logic [3:0] d;
        all_nine = 1'b1;
        for (int i = 0; i < MARK_DIGITS; i++) begin
            all_nine = all_nine && (bcd_reg[4*i +: 4] == 4'd9);
        end
        carry   = !all_nine;
        bcd_inc = bcd_reg;
        for (int i = 0; i < MARK_DIGITS; i++) begin
            d = bcd_reg[4*i +: 4];
            if (carry) begin
                if (d == 4'd9) begin
                    bcd_inc[4*i +: 4] = 4'd0;
                end else begin
                    bcd_inc[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        white  = is_white(s_word.code_point);
        is_at  = (s_word.code_point == CH_AT);
        is_dot = (s_word.code_point == CH_DOT);
        mark   = pend_reg && white;

        q_cmd.code_point = s_word.code_point;
        q_cmd.last       = s_word.message_last;
        q_cmd.emit_dot   = pend_reg;
        if (mark) begin
            q_cmd.body = BODY_MARK;
        end else if (is_at) begin
            q_cmd.body = BODY_AT2;
        end else if (is_dot && !s_word.message_last) begin
            q_cmd.body = BODY_NONE;
        end else begin
            q_cmd.body = BODY_CHAR;
        end
        push   = pend_reg || !(is_dot && !s_word.message_last);
        q_push = accept && push;

        pend_next = pend_reg;
        bcd_next  = bcd_reg;
        if (accept) begin
            pend_next = !mark && is_dot && !s_word.message_last;
            bcd_next  = mark ? bcd_inc : bcd_reg;
            if (s_word.message_last) begin
                pend_next = 1'b0;
                bcd_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            bcd_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            bcd_reg  <= bcd_next;
        end
    end

    `SIMI_ASSERT_NXT(a_msg_end_clears, aclk, aresetn, accept && s_word.message_last,
        !pend_reg && (bcd_reg == '0), "state not cleared after message end")
    `SIMI_ASSERT_IMP(a_no_push_full, aclk, aresetn, q_push, !q_full,
        "command pushed into full queue")
    `SIMI_ASSERT_NXT(a_dot_held, aclk, aresetn, accept && is_dot && !s_word.message_last,
        pend_reg, "period not held back")

endmodule

[design/simi_fifo.sv]
// short command queue between front and back ends
module simi_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = simi_pkg::FIFO_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             head_valid,
    output logic             full
);
    import simi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/simi_back.sv]
// back end: expands each command into output words, one per cycle unless the output stalls
`include "sentence_index_mark_inserter_top_defines.svh"

module simi_back #(
    parameter int MARK_DIGITS = simi_pkg::MARK_DIGITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     head_valid,
    input  simi_pkg::cmd_t           head_cmd,
    input  logic [4*MARK_DIGITS-1:0] head_bcd,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output simi_pkg::out_word_t      m_word
);
    import simi_pkg::*;

    localparam int LEN_W = $clog2(MARK_DIGITS + 5);

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        word_reg, word_next;

    logic [LEN_W-1:0] ndig, body_len, n_len, j, sel;
    logic [3:0]       digit;
    logic [CP_W-1:0]  cp;
    logic             load, last_el;

    always_comb begin
        ndig = '0;
        for (int i = 0; i < MARK_DIGITS; i++) begin
            if (head_bcd[4*i +: 4] != 4'd0) begin
                ndig = LEN_W'(i + 1);
            end
        end
        if (ndig == '0) begin
            ndig = LEN_W'(1);
        end

        case (head_cmd.body)
            BODY_NONE: body_len = '0;
            BODY_CHAR: body_len = LEN_W'(1);
            BODY_AT2:  body_len = LEN_W'(2);
            BODY_MARK: body_len = ndig + LEN_W'(3);
            default:   body_len = '0;
        endcase
        n_len   = body_len + LEN_W'(head_cmd.emit_dot);
        last_el = (idx_reg == n_len - LEN_W'(1));
        j       = idx_reg - LEN_W'(head_cmd.emit_dot);
        sel     = ndig - j;

        digit = 4'd0;
        for (int i = 0; i < MARK_DIGITS; i++) begin
            if (sel == LEN_W'(i)) begin
                digit = head_bcd[4*i +: 4];
            end
        end

        if (head_cmd.emit_dot && (idx_reg == '0)) begin
            cp = CH_DOT;
        end else begin
            case (head_cmd.body)
                BODY_AT2: cp = CH_AT;
                BODY_MARK: begin
                    if (j == '0 || j == ndig + LEN_W'(1)) begin
                        cp = CH_AT;
                    end else if (j <= ndig) begin
                        cp = CH_ZERO + CP_W'(digit);
                    end else begin
                        cp = head_cmd.code_point;
                    end
                end
                default: cp = head_cmd.code_point;
            endcase
        end

        load = head_valid && (!m_valid_reg || m_ready);
        pop  = load && last_el;

        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        word_next    = word_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next             = 1'b1;
            word_next.out_code_point = cp;
            word_next.run_last       = last_el;
            word_next.message_end    = last_el && head_cmd.last;
            idx_next                 = last_el ? '0 : idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = word_reg;

    `SIMI_ASSERT_IMP(a_idx_has_head, aclk, aresetn, idx_reg != '0, head_valid, "expansion in progress without a queued command")
    `SIMI_ASSERT_NXT(a_pop_run_last, aclk, aresetn, pop, m_valid_reg && word_reg.run_last, "command retired without a closing word")
    `SIMI_ASSERT_IMP(a_end_is_run_last, aclk, aresetn, m_valid_reg && word_reg.message_end, word_reg.run_last, "message end on a word that does not close its run")

endmodule

[design/sentence_index_mark_inserter_top.sv]
// top level of the sentence index mark inserter
// an accepted item passes through the command queue and the back end's output word register
// one output word per cycle unless m_ready stalls; a k-word item holds the back end
// a held-back period yields no word; the FIFO_DEPTH-entry command queue stalls intake when full
// reset: synchronous active-low aresetn clears the held period, mark number and queue
module sentence_index_mark_inserter_top #(
    parameter int MARK_DIGITS = simi_pkg::MARK_DIGITS_DEF,
    parameter int FIFO_DEPTH  = simi_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  simi_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output simi_pkg::out_word_t m_word
);
    import simi_pkg::*;

    localparam int BCD_W  = 4 * MARK_DIGITS;
    localparam int CMD_W  = $bits(cmd_t);
    localparam int FIFO_W = CMD_W + BCD_W;

    logic              q_push, q_full, q_pop, q_head_valid;
    cmd_t              q_cmd, head_cmd;
    logic [BCD_W-1:0]  q_bcd, head_bcd;
    logic [FIFO_W-1:0] q_wr_data, q_rd_data;

    simi_front #(
        .MARK_DIGITS (MARK_DIGITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd),
        .q_bcd   (q_bcd)
    );

    assign q_wr_data = {q_cmd, q_bcd};

    simi_fifo #(
        .WIDTH (FIFO_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .wr_data    (q_wr_data),
        .pop        (q_pop),
        .rd_data    (q_rd_data),
        .head_valid (q_head_valid),
        .full       (q_full)
    );

    assign head_cmd = q_rd_data[FIFO_W-1:BCD_W];
    assign head_bcd = q_rd_data[BCD_W-1:0];

    simi_back #(
        .MARK_DIGITS (MARK_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd),
        .head_bcd   (head_bcd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

endmodule
